[rtl/psrl_pkg.sv]
`timescale 1ns / 1ps
package psrl_pkg;
  localparam int DefNumSets = 256;
  localparam int DefNumWays = 4;
  localparam int AddrW = 64;
  localparam int TimeW = 32;
  localparam int CountW = 32;
  localparam int LimitW = 20;
  localparam int VerdictW = 2;
  localparam logic [TimeW-1:0] IdleSeconds = 32'd60;
  localparam logic [CountW-1:0] CountMax = 32'hFFFF_FFFF;
  localparam int HashModulus = 1031;
  localparam int HashShift = 5;
  // floor(h/1031) = (h * HashRecip) >> HashRecipShift for any 32-bit h
  localparam int HashRecipShift = 42;
  localparam logic [31:0] HashRecip =
    32'(((64'd1 << HashRecipShift) + 64'(HashModulus) - 64'd1) / 64'(HashModulus));

  localparam logic [VerdictW-1:0] VerdictServe = 2'd0;
  localparam logic [VerdictW-1:0] VerdictDeny = 2'd1;
  localparam logic [VerdictW-1:0] VerdictFull = 2'd2;

  // one table entry as stored in memory
  typedef struct packed {
    logic valid;
    logic [AddrW-1:0] addr_high;
    logic [AddrW-1:0] addr_low;
    logic [CountW-1:0] count;
    logic [TimeW-1:0] last_seen;
  } entry_t;

  // one hash step: h = h*33 ^ byte
  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = h + (h << HashShift);
    return t ^ {24'd0, b};
  endfunction
endpackage

[rtl/psrl_hash.sv]
`timescale 1ns / 1ps
module psrl_hash #(
  parameter int NUM_SETS = psrl_pkg::DefNumSets
) (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  logic [psrl_pkg::AddrW-1:0] hi,
  input  logic [psrl_pkg::AddrW-1:0] lo,
  output logic done,
  output logic [10:0] set_idx
);
  import psrl_pkg::*;

  // residue/NUM_SETS by reciprocal, exact for any 11-bit residue
  localparam int SetShift = 11 + $clog2(NUM_SETS);
  localparam logic [13:0] SetRecip =
    14'(((64'd1 << SetShift) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));

  typedef enum logic [2:0] {S_IDLE, S_HASH, S_MUL, S_FOLD, S_SET} state_t;
  state_t state;
  logic [3:0] idx;
  logic [31:0] h;
  logic [7:0] cur_byte;
  logic [127:0] addr;
  logic [63:0] prod;
  logic [31:0] hash_rem;
  logic [10:0] residue;
  logic [24:0] set_prod;
  logic [10:0] set_quo;
  logic [22:0] set_sub;

  assign addr = {hi, lo};
  assign cur_byte = addr[(4'd15 - idx)*8 +: 8];

  // subtract the quotient multiple to get h mod 1031
  assign hash_rem = h - 32'(prod[63:HashRecipShift]) * 32'(HashModulus);

  // reduce the residue to a set index
  assign set_prod = 25'(residue) * 25'(SetRecip);
  assign set_quo = 11'(set_prod >> SetShift);
  assign set_sub = 23'(set_quo) * 23'(NUM_SETS);

  // hash bytes one a cycle, then reduce by reciprocal multiplication
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (go) begin
            h <= 32'd0;
            idx <= 4'd0;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          h <= hash_step(h, cur_byte);
          idx <= idx + 4'd1;
          if (idx == 4'd15) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= 64'(h) * 64'(HashRecip);
          state <= S_FOLD;
        end
        S_FOLD: begin
          residue <= hash_rem[10:0];
          state <= S_SET;
        end
        S_SET: begin
          set_idx <= residue - set_sub[10:0];
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/per_source_request_rate_limiter.sv]
`timescale 1ns / 1ps
// Per-source request rate limiter.
// Channels: pulse start with source_high, source_low, time_seconds while busy
// is low; the word is captured at that edge. One verdict word follows on
// verdict, marked by a one-cycle valid strobe; the receiver cannot stall it.
// request_limit is written with limit_we/limit_data; the user must write it
// only while idle, as the block itself does not enforce that.
// With tracking off (limit zero), valid rises at the edge after the
// accepting one. Otherwise the hash takes the 16 address bytes one a cycle,
// then two reductions (S_MUL, S_FOLD, S_SET); each way searched then takes
// a read and a compare state, up to a hit or the last way, and S_DONE
// raises valid. busy is low while valid is high, so the next word can be
// taken then. A sweep, run first when a request comes more than 60 s after
// the last sweep with tracking on, reads each entry, then writes it back.
// Reset: busy stays high while a clearing pass writes every entry invalid;
// last sweep time and the limit clear to zero.
module per_source_request_rate_limiter #(
  parameter int NUM_SETS = psrl_pkg::DefNumSets,
  parameter int NUM_WAYS = psrl_pkg::DefNumWays
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [psrl_pkg::AddrW-1:0] source_high,
  input  logic [psrl_pkg::AddrW-1:0] source_low,
  input  logic [psrl_pkg::TimeW-1:0] time_seconds,
  input  logic limit_we,
  input  logic [psrl_pkg::LimitW-1:0] limit_data,
  output logic valid,
  output logic [psrl_pkg::VerdictW-1:0] verdict
);
  import psrl_pkg::*;

  localparam int Entries = NUM_SETS * NUM_WAYS;
  localparam int EW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SWRD, S_SWCHK, S_HASH, S_RD, S_CHK, S_DONE
  } state_t;
  state_t state;

  logic [LimitW-1:0] limit;
  logic [TimeW-1:0] last_sweep;
  logic [AddrW-1:0] hi, lo;
  logic [TimeW-1:0] now;
  entry_t mem [Entries];
  entry_t rd;
  logic [EW-1:0] raddr;
  logic we;
  logic [EW-1:0] waddr;
  entry_t wdata;
  logic [EW:0] sidx;
  logic [WW:0] way;
  logic [SW-1:0] set;
  logic [EW-1:0] base;
  logic free_found;
  logic [WW-1:0] free_way;
  logic take_free;
  logic [WW-1:0] pick_way;
  logic hash_go, hash_done;
  logic [10:0] hash_set;
  logic [LimitW-1:0] tenth;
  logic [EW-1:0] cur_e;
  logic stale, low;
  entry_t swept, bumped;

  // limit/10 by reciprocal: 838861 = ceil(2^23/10), exact for 20-bit limits
  logic [43:0] tenth_prod;
  assign tenth_prod = 44'(limit) * 44'd838861;
  assign tenth = LimitW'(tenth_prod >> 23);

  psrl_hash #(
    .NUM_SETS(NUM_SETS)
  ) u_hash (
    .clk(clk), .rst(rst), .go(hash_go), .hi(hi), .lo(lo),
    .done(hash_done), .set_idx(hash_set)
  );

  // table memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  assign busy = (state != S_IDLE);
  assign base = EW'(set) * EW'(NUM_WAYS);
  assign cur_e = base + EW'(way[WW-1:0]);

  assign stale = ({1'b0, rd.last_seen} + 33'(IdleSeconds)) < {1'b0, now};
  assign low = rd.count <= 32'(tenth);

  // take the lowest free way seen so far
  assign take_free = !rd.valid && !free_found;
  assign pick_way = take_free ? way[WW-1:0] : free_way;

  // build the swept and the bumped entry from the word read
  always_comb begin
    swept = rd;
    if (stale || low) begin
      swept.valid = 1'b0;
    end else begin
      swept.count = rd.count >> 1;
    end
    bumped = rd;
    bumped.last_seen = now;
    if (rd.count != CountMax) begin
      bumped.count = rd.count + 32'd1;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    valid <= 1'b0;
    we <= 1'b0;
    hash_go <= 1'b0;
    if (rst) begin
      state <= S_CLR;
      sidx <= '0;
      limit <= '0;
      last_sweep <= '0;
    end else begin
      if (limit_we) limit <= limit_data;
      unique case (state)
        S_CLR: begin
          we <= 1'b1;
          waddr <= sidx[EW-1:0];
          wdata <= '0;
          if (sidx == (EW+1)'(Entries - 1)) begin
            state <= S_IDLE;
          end else begin
            sidx <= sidx + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            hi <= source_high;
            lo <= source_low;
            now <= time_seconds;
            if (limit == '0) begin
              verdict <= VerdictServe;
              state <= S_DONE;
            end else if ({1'b0, time_seconds} > {1'b0, last_sweep} + 33'(IdleSeconds)) begin
              last_sweep <= time_seconds;
              sidx <= '0;
              raddr <= '0;
              state <= S_SWRD;
            end else begin
              hash_go <= 1'b1;
              state <= S_HASH;
            end
          end
        end
        S_SWRD: state <= S_SWCHK;
        S_SWCHK: begin
          if (rd.valid && (stale || low || rd.count < 32'(limit))) begin
            we <= 1'b1;
            waddr <= sidx[EW-1:0];
            wdata <= swept;
          end
          if (sidx == (EW+1)'(Entries - 1)) begin
            hash_go <= 1'b1;
            state <= S_HASH;
          end else begin
            sidx <= sidx + 1'b1;
            raddr <= EW'(sidx + 1'b1);
            state <= S_SWRD;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            set <= SW'(hash_set);
            way <= '0;
            free_found <= 1'b0;
            raddr <= EW'(hash_set) * EW'(NUM_WAYS);
            state <= S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (rd.valid && rd.addr_high == hi && rd.addr_low == lo) begin
            we <= 1'b1;
            waddr <= cur_e;
            wdata <= bumped;
            verdict <= (bumped.count > 32'(limit)) ? VerdictDeny : VerdictServe;
            state <= S_DONE;
          end else begin
            if (take_free) begin
              free_found <= 1'b1;
              free_way <= way[WW-1:0];
            end
            if (way == (WW+1)'(NUM_WAYS - 1)) begin
              if (free_found || take_free) begin
                we <= 1'b1;
                waddr <= base + EW'(pick_way);
                wdata <= '{valid: 1'b1, addr_high: hi, addr_low: lo,
                           count: 32'd1, last_seen: now};
                verdict <= VerdictServe;
              end else begin
                verdict <= VerdictFull;
              end
              state <= S_DONE;
            end else begin
              way <= way + 1'b1;
              raddr <= cur_e + EW'(1);
              state <= S_RD;
            end
          end
        end
        S_DONE: begin
          valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[tb/tb_per_source_request_rate_limiter.sv]
`timescale 1ns / 1ps
module tb_per_source_request_rate_limiter;
  import psrl_pkg::*;

  localparam int NSets = 256;
  localparam int NWays = 4;
  localparam int NEntries = NSets * NWays;
  localparam int LimitCycles = 20000000;

  // per-source table model with expected verdict queue
  class verdict_board;
    bit               live [NEntries];
    logic [AddrW-1:0] hi_tag [NEntries];
    logic [AddrW-1:0] lo_tag [NEntries];
    logic [31:0]      hits [NEntries];
    logic [31:0]      seen [NEntries];
    logic [31:0]      swept_at;
    logic [31:0]      limit;
    logic [VerdictW-1:0] pending [$];

    function void clear();
      foreach (live[i]) live[i] = 0;
      swept_at = 0;
      limit = 0;
      pending.delete();
    endfunction

    function int set_of(logic [63:0] hi, logic [63:0] lo);
      logic [31:0] h;
      logic [7:0] b;
      h = 0;
      for (int k = 0; k < 16; k++) begin
        b = (k < 8) ? hi[63-8*k -: 8] : lo[63-8*(k-8) -: 8];
        h = (h + (h << 5)) ^ {24'd0, b};
      end
      return (h % 1031) % NSets;
    endfunction

    // note one accepted request word and predict its verdict
    function void note_request(logic [63:0] hi, logic [63:0] lo, logic [31:0] now);
      int base, free_way;
      if (limit == 0) begin
        pending.push_back(VerdictServe);
        return;
      end
      if ({32'd0, now} > {32'd0, swept_at} + 64'd60) begin
        for (int e = 0; e < NEntries; e++) begin
          if (!live[e]) continue;
          if ({32'd0, seen[e]} + 64'd60 < {32'd0, now} || hits[e] <= limit / 10)
            live[e] = 0;
          else if (hits[e] < limit)
            hits[e] = hits[e] / 2;
        end
        swept_at = now;
      end
      base = set_of(hi, lo) * NWays;
      free_way = -1;
      for (int w = 0; w < NWays; w++) begin
        if (live[base+w]) begin
          if (hi_tag[base+w] == hi && lo_tag[base+w] == lo) begin
            seen[base+w] = now;
            if (hits[base+w] != CountMax) hits[base+w]++;
            pending.push_back(hits[base+w] > limit ? VerdictDeny : VerdictServe);
            return;
          end
        end else if (free_way < 0) begin
          free_way = w;
        end
      end
      if (free_way < 0) begin
        pending.push_back(VerdictFull);
        return;
      end
      live[base+free_way] = 1;
      hi_tag[base+free_way] = hi;
      lo_tag[base+free_way] = lo;
      hits[base+free_way] = 1;
      seen[base+free_way] = now;
      pending.push_back(VerdictServe);
    endfunction

    // compare one verdict word against the oldest expectation
    function bit check_verdict(logic [VerdictW-1:0] got, output string msg);
      logic [VerdictW-1:0] want;
      if (pending.size() == 0) begin
        msg = $sformatf("unexpected verdict %0d", got);
        return 0;
      end
      want = pending.pop_front();
      if (got !== want) begin
        msg = $sformatf("verdict %0d, expected %0d", got, want);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic clk, rst, start, busy, limit_we, valid;
  logic [AddrW-1:0] source_high, source_low;
  logic [TimeW-1:0] time_seconds;
  logic [LimitW-1:0] limit_data;
  logic [VerdictW-1:0] verdict;

  verdict_board board;
  int errors;
  int cycles;
  logic [31:0] clock_now;
  logic [63:0] pool_hi [16];
  logic [63:0] pool_lo [16];

  per_source_request_rate_limiter u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .source_high(source_high), .source_low(source_low), .time_seconds(time_seconds),
    .limit_we(limit_we), .limit_data(limit_data),
    .valid(valid), .verdict(verdict)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // check verdict words as they appear
  always @(posedge clk) begin
    string msg;
    cycles <= cycles + 1;
    if (!rst && valid && !board.check_verdict(verdict, msg)) report(msg);
    if (cycles > LimitCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  // hold one request until accepted
  task automatic send_request(logic [63:0] hi, logic [63:0] lo, logic [31:0] now);
    start <= 1;
    source_high <= hi;
    source_low <= lo;
    time_seconds <= now;
    do @(posedge clk); while (busy);
    board.note_request(hi, lo, now);
  endtask

  task automatic pause(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [19:0] value);
    drain();
    limit_we <= 1;
    limit_data <= value;
    @(posedge clk);
    limit_we <= 0;
    board.limit = {12'd0, value};
    @(posedge clk);
  endtask

  // random request: mostly a small pool of sources, time drifting forward
  task automatic random_request();
    logic [63:0] hi, lo;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 16) begin
      hi = pool_hi[pick];
      lo = pool_lo[pick];
    end else begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
    end
    case ($urandom_range(0, 19))
      0: clock_now = clock_now + $urandom_range(61, 200);
      1: clock_now = clock_now - $urandom_range(0, 30);
      2: clock_now = $urandom;
      default: clock_now = clock_now + $urandom_range(0, 2);
    endcase
    send_request(hi, lo, clock_now);
  endtask

  initial begin
    logic [19:0] limits [6];
    logic [63:0] same_lo [6];
    logic [63:0] cand;
    int n_same;
    board = new();
    board.clear();
    rst = 1;
    start = 0;
    limit_we = 0;
    limit_data = 0;
    source_high = 0;
    source_low = 0;
    time_seconds = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // gather six sources that land in the same set as the all-zero source
    cand = 64'd0;
    n_same = 0;
    while (n_same < 6 && cand < 64'd1000000) begin
      if (board.set_of('0, cand) == board.set_of('0, '0)) begin
        same_lo[n_same] = cand;
        n_same++;
      end
      cand++;
    end

    // tracking off, extremes of the fields
    send_request('1, '1, '1);
    send_request('0, '0, '0);

    // tracking on: flood one source, fill one set, sweep, time backwards
    write_limit(20'd3);
    for (int i = 0; i < 5; i++) send_request(64'h1, 64'h2, 32'd10);
    for (int i = 0; i < 6; i++) send_request('0, same_lo[i], 32'd11);
    send_request('1, '1, 32'd11);
    send_request(64'h1, 64'h2, 32'd200);
    send_request(64'h1, 64'h2, 32'd5);
    send_request(64'h1, 64'h2, 32'hFFFF_FFFF);
    send_request(64'h1, 64'h2, 32'hFFFF_FFFF);
    write_limit(20'hFFFFF);
    send_request('1, '0, 32'd0);
    send_request('1, '0, 32'd1);

    // random phases over several limits
    limits = '{1, 2, 10, 25, 20'hFFFFF, 0};
    foreach (pool_hi[i]) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
    end
    clock_now = 1000;
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(ph == 3 ? 20'($urandom_range(3, 40)) : limits[ph]);
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(0, 7) == 0) pause($urandom_range(1, 20));
        random_request();
      end
    end

    drain();
    repeat (3000) @(posedge clk);
    if (errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
